FILE: rtl/tlr_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlr_pkg
// Shared constants and types of the telnet line receiver.
// ---------------------------------------------------------------------------
package tlr_pkg;

  // line store size; a line holds at most LINE_CAPACITY-1 characters
  localparam int LINE_CAPACITY = 64;
  localparam int LEN_W         = (LINE_CAPACITY > 2) ? $clog2(LINE_CAPACITY) : 1;

  // telnet command codes and control characters
  localparam logic [7:0] B_IAC  = 8'd255;
  localparam logic [7:0] B_DONT = 8'd254;
  localparam logic [7:0] B_DO   = 8'd253;
  localparam logic [7:0] B_WONT = 8'd252;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_SB   = 8'd250;
  localparam logic [7:0] B_SE   = 8'd240;
  localparam logic [7:0] B_CR   = 8'd13;
  localparam logic [7:0] B_LF   = 8'd10;
  localparam logic [7:0] B_SP   = 8'd32;
  localparam logic [7:0] B_TAB  = 8'd9;
  localparam logic [7:0] B_VT   = 8'd11;
  localparam logic [7:0] B_FF   = 8'd12;

  // telnet parser state
  typedef enum logic [2:0] {
    ST_DATA    = 3'd0,
    ST_IAC     = 3'd1,
    ST_OPT     = 3'd2,
    ST_SB      = 3'd3,
    ST_SB_DATA = 3'd4,
    ST_SB_IAC  = 3'd5
  } parse_state_t;

  // line control state
  typedef enum logic [1:0] {
    CS_RX   = 2'd0,
    CS_EMIT = 2'd1,
    CS_LF   = 2'd2
  } ctrl_state_t;

endpackage

FILE: rtl/tlr_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlr_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module tlr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/telnet_line_receiver_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// telnet_line_receiver_unit
// Strips telnet control from received bytes, collects lines in a RAM and
// emits each trimmed line followed by a newline marked last; a line that overflows the store is dropped.
//
//   channel | handshake             | payload
//   --------+-----------------------+--------------------------
//   input   | in_valid / in_ready   | rx_byte
//   output  | out_valid / out_ready | line_byte, last_of_line
//
// A received byte is taken every cycle while no line is being read out.
// A newline starts the readout: each character is read from the line RAM,
// whose read data is registered, into the output register before the next
// read is issued, then the newline follows (with no reads when the line is empty or all blank).
// Input is held off during readout; output stalls pause it in place.
// Reset clears the parser, the line length and the discard flag; the RAM
// is not cleared, only written entries are ever read.
// ---------------------------------------------------------------------------
module telnet_line_receiver_unit
  import tlr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] line_byte,
  output logic       last_of_line
);

  parse_state_t     parse_state, parse_state_next;
  ctrl_state_t      ctrl_state, ctrl_state_next;
  logic [LEN_W-1:0] line_length, line_length_next;
  logic             discarding, discarding_next;
  logic             has_text, has_text_next;     // a non-blank is held
  logic [LEN_W-1:0] first_text, first_text_next; // first non-blank index
  logic [LEN_W-1:0] text_end, text_end_next;     // one past last non-blank
  logic [LEN_W-1:0] rd_ptr, rd_ptr_next;
  logic [LEN_W-1:0] rd_end, rd_end_next;
  logic             rd_pend, rd_pend_next;
  logic             out_valid_next;
  logic [7:0]       line_byte_next;
  logic             last_next;

  logic             accept;
  logic             have_ch;
  logic [7:0]       ch;
  logic             ch_blank;
  logic             wr_en;
  logic             rd_en;
  logic [7:0]       rd_data;
  logic             slot_free;

  assign in_ready  = (ctrl_state == CS_RX);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  // telnet parser
  always_comb begin
    parse_state_next = parse_state;
    have_ch          = 1'b0;
    ch               = rx_byte;
    case (parse_state)
      ST_IAC: begin
        if (rx_byte == B_IAC) begin
          parse_state_next = ST_DATA;
          have_ch          = 1'b1;
        end else if (rx_byte inside {B_DO, B_DONT, B_WILL, B_WONT}) begin
          parse_state_next = ST_OPT;
        end else if (rx_byte == B_SB) begin
          parse_state_next = ST_SB;
        end else begin
          parse_state_next = ST_DATA;
        end
      end
      ST_OPT:     parse_state_next = ST_DATA;
      ST_SB:      parse_state_next = ST_SB_DATA;
      ST_SB_DATA: begin
        if (rx_byte == B_IAC) begin
          parse_state_next = ST_SB_IAC;
        end
      end
      ST_SB_IAC:  parse_state_next = (rx_byte == B_SE) ? ST_DATA : ST_SB_DATA;
      default: begin
        if (rx_byte == B_IAC) begin
          parse_state_next = ST_IAC;
        end else begin
          parse_state_next = ST_DATA;
          have_ch          = 1'b1;
        end
      end
    endcase
    ch_blank = (ch inside {B_SP, B_TAB, B_VT, B_FF}) && !(parse_state == ST_IAC);
  end

  // line collection, readout sequencing and output register
  always_comb begin
    ctrl_state_next  = ctrl_state;
    line_length_next = line_length;
    discarding_next  = discarding;
    has_text_next    = has_text;
    first_text_next  = first_text;
    text_end_next    = text_end;
    rd_ptr_next      = rd_ptr;
    rd_end_next      = rd_end;
    rd_pend_next     = 1'b0;
    out_valid_next   = out_valid && !out_ready;
    line_byte_next   = line_byte;
    last_next        = last_of_line;
    wr_en            = 1'b0;
    rd_en            = 1'b0;
    case (ctrl_state)
      CS_RX: begin
        if (accept && have_ch && ch != B_CR) begin
          if (ch == B_LF) begin
            if (discarding) begin
              discarding_next = 1'b0;
            end else if (has_text) begin
              rd_ptr_next     = first_text;
              rd_end_next     = text_end;
              ctrl_state_next = CS_EMIT;
            end else begin
              ctrl_state_next = CS_LF;
            end
            line_length_next = '0;
            has_text_next    = 1'b0;
          end else if (!discarding) begin
            if (line_length < LEN_W'(LINE_CAPACITY - 1)) begin
              wr_en            = 1'b1;
              line_length_next = line_length + 1'b1;
              if (!ch_blank) begin
                if (!has_text) begin
                  first_text_next = line_length;
                end
                has_text_next = 1'b1;
                text_end_next = line_length + 1'b1;
              end
            end else begin
              line_length_next = '0;
              discarding_next  = 1'b1;
              has_text_next    = 1'b0;
            end
          end
        end
      end
      CS_EMIT: begin
        // read data lands in the output slot, freed when the read was issued
        if (rd_pend) begin
          out_valid_next = 1'b1;
          line_byte_next = rd_data;
          last_next      = 1'b0;
        end else if (rd_ptr == rd_end) begin
          ctrl_state_next = CS_LF;
        end else if (slot_free) begin
          rd_en        = 1'b1;
          rd_pend_next = 1'b1;
          rd_ptr_next  = rd_ptr + 1'b1;
        end
      end
      CS_LF: begin
        if (slot_free) begin
          out_valid_next  = 1'b1;
          line_byte_next  = B_LF;
          last_next       = 1'b1;
          ctrl_state_next = CS_RX;
        end
      end
      default: ctrl_state_next = CS_RX;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state <= ST_DATA;
      ctrl_state  <= CS_RX;
      line_length <= '0;
      discarding  <= 1'b0;
      has_text    <= 1'b0;
      rd_pend     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (accept) begin
        parse_state <= parse_state_next;
      end
      ctrl_state  <= ctrl_state_next;
      line_length <= line_length_next;
      discarding  <= discarding_next;
      has_text    <= has_text_next;
      rd_pend     <= rd_pend_next;
      out_valid   <= out_valid_next;
    end
  end

  // payload and index registers
  always_ff @(posedge clk) begin
    first_text   <= first_text_next;
    text_end     <= text_end_next;
    rd_ptr       <= rd_ptr_next;
    rd_end       <= rd_end_next;
    line_byte    <= line_byte_next;
    last_of_line <= last_next;
  end

  // line store
  tlr_ram #(
    .WIDTH(8),
    .DEPTH(LINE_CAPACITY)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (line_length),
    .wr_data (ch),
    .rd_en   (rd_en),
    .rd_addr (rd_ptr),
    .rd_data (rd_data)
  );

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Testbench for telnet_line_receiver_unit. A queue of raw link bytes, built
// up front, feeds a clocked driver; a telnet parser and line assembler kept
// in the bench predicts every emitted line character, and a clocked monitor
// compares each output transaction against the oldest prediction. Both
// sides idle at random in phases, and a watchdog ends a stuck run.
// ---------------------------------------------------------------------------
module tb_top;
  import tlr_pkg::*;

  localparam int         RAND_ITEMS   = 310;
  localparam int         DRAIN_CYCLES = 16;
  localparam int         IDLE_LIMIT   = 4000;
  localparam logic [7:0] B_NOP        = 8'd241;
  localparam logic [7:0] B_DEL        = 8'd127;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } line_char_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] line_byte;
  logic       last_of_line;

  // raw bytes still to send and line characters still awaited
  logic [7:0] link_bytes[$];
  line_char_t exp_line_q[$];
  line_char_t exp_r;

  // predicted receiver state
  parse_state_t tel_state;
  logic [7:0]   line_mem[0:LINE_CAPACITY-1];
  int           held;
  logic         dropping;

  int stim_total, planned, bytes_sent, phase;
  int lines_closed, lines_dropped, overflows, chars_checked, err_cnt;
  int r, r2;

  telnet_line_receiver_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .line_byte    (line_byte),
    .last_of_line (last_of_line)
  );

  always #4 clk = ~clk;

  function automatic bit is_blank(input logic [7:0] c);
    return c == B_SP || c == B_TAB || c == B_VT || c == B_FF;
  endfunction

  // telnet parse and line assembly for one received byte
  task automatic absorb_byte(input logic [7:0] b);
    logic have;
    int   lo, hi, k;
    have = 1'b0;
    case (tel_state)
      ST_IAC: begin
        if (b == B_IAC) begin
          tel_state = ST_DATA;
          have = 1'b1;
        end else if (b == B_DO || b == B_DONT || b == B_WILL || b == B_WONT) begin
          tel_state = ST_OPT;
        end else if (b == B_SB) begin
          tel_state = ST_SB;
        end else begin
          tel_state = ST_DATA;
        end
      end
      ST_OPT:     tel_state = ST_DATA;
      ST_SB:      tel_state = ST_SB_DATA;
      ST_SB_DATA: if (b == B_IAC) tel_state = ST_SB_IAC;
      ST_SB_IAC:  tel_state = (b == B_SE) ? ST_DATA : ST_SB_DATA;
      default: begin
        if (b == B_IAC) begin
          tel_state = ST_IAC;
        end else begin
          tel_state = ST_DATA;
          have = 1'b1;
        end
      end
    endcase
    if (!have || b == B_CR) return;
    // newline closes the line, trimmed at both ends
    if (b == B_LF) begin
      if (dropping) begin
        held = 0;
        dropping = 1'b0;
        lines_dropped++;
        return;
      end
      hi = held;
      while (hi > 0 && is_blank(line_mem[hi-1])) hi--;
      lo = 0;
      while (lo < hi && is_blank(line_mem[lo])) lo++;
      for (k = lo; k < hi; k++) exp_line_q.push_back('{ch: line_mem[k], last: 1'b0});
      exp_line_q.push_back('{ch: B_LF, last: 1'b1});
      held = 0;
      lines_closed++;
      return;
    end
    if (dropping) return;
    // overlong line is thrown away up to the next newline
    if (held < LINE_CAPACITY - 1) begin
      line_mem[held] = b;
      held++;
    end else begin
      held = 0;
      dropping = 1'b1;
      overflows++;
    end
  endtask

  // stimulus builders
  task automatic put(input logic [7:0] b);
    link_bytes.push_back(b);
  endtask

  task automatic put_blank();
    case ($urandom_range(0, 3))
      0:       put(B_SP);
      1:       put(B_TAB);
      2:       put(B_VT);
      default: put(B_FF);
    endcase
    planned++;
  endtask

  task automatic put_cmd();
    logic [7:0] b;
    int         n;
    case ($urandom_range(0, 3))
      0: begin
        put(B_IAC);
        case ($urandom_range(0, 3))
          0:       put(B_DO);
          1:       put(B_DONT);
          2:       put(B_WILL);
          default: put(B_WONT);
        endcase
        put(8'($urandom_range(0, 255)));
      end
      1: begin
        // subnegotiation with escaped and stray commands inside
        put(B_IAC);
        put(B_SB);
        put(8'($urandom_range(0, 255)));
        n = $urandom_range(0, 6);
        repeat (n) begin
          b = 8'($urandom_range(0, 255));
          put(b);
          if (b == B_IAC) put(8'($urandom_range(241, 255)));
        end
        put(B_IAC);
        put(B_SE);
      end
      2: begin
        put(B_IAC);
        put(8'($urandom_range(0, 249)));
      end
      default: put(B_CR);
    endcase
  endtask

  // one data character of a line, possibly with telnet control around it
  task automatic put_char();
    logic [7:0] b;
    r2 = $urandom_range(0, 99);
    if (r2 < 15) begin
      put_blank();
      return;
    end
    if (r2 < 20) begin
      put(B_IAC);
      put(B_IAC);
      planned++;
      return;
    end
    if (r2 < 25) put_cmd();
    if (r2 < 75) begin
      b = 8'($urandom_range(33, 126));
    end else begin
      b = 8'($urandom_range(0, 254));
      if (b == B_LF || b == B_CR) b = B_DEL;
    end
    put(b);
    planned++;
  endtask

  task automatic put_line(input int len, input bit pad);
    int k;
    if (pad) repeat ($urandom_range(0, 3)) put_blank();
    for (k = 0; k < len; k++) put_char();
    if (pad) repeat ($urandom_range(0, 3)) put_blank();
    put(B_LF);
    planned++;
  endtask

  // stimulus, reset and end of run
  initial begin
    tel_state = ST_DATA;
    held = 0;
    dropping = 1'b0;

    // empty line, blank-only line
    put(B_LF);
    put(B_SP); put(B_TAB); put(B_LF);
    // every telnet command mixed into one line, escaped 255 next to blanks
    put(B_VT);
    put(B_IAC); put(B_DO); put(8'd1);
    put(8'd0);
    put(B_IAC); put(B_IAC);
    put(B_CR);
    put(B_IAC); put(B_WILL); put(8'd24);
    put(B_DONT);
    put(B_IAC); put(B_SB); put(B_IAC); put("x"); put(B_IAC); put("y"); put(B_IAC); put(B_SE);
    put(B_IAC); put(B_NOP);
    put(B_IAC); put(B_DONT); put(B_IAC);
    put(B_IAC); put(B_WONT); put(8'd31);
    put(B_IAC); put(B_IAC);
    put(B_FF);
    put(B_LF);

    // longest line that fits, then one character too many
    planned = 0;
    put_line(LINE_CAPACITY - 1, 1'b0);
    put_line(LINE_CAPACITY, 1'b0);
    while (link_bytes.size() < RAND_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        r2 = $urandom_range(0, 99);
        if (r2 < 15) put_line($urandom_range(LINE_CAPACITY - 6, LINE_CAPACITY + 4), 1'b1);
        else if (r2 < 25) put_line(0, 1'b1);
        else put_line($urandom_range(1, 20), 1'b1);
      end else if (r < 85) begin
        put_cmd();
      end else begin
        // raw noise, then a resync attempt
        repeat ($urandom_range(1, 4)) put(8'($urandom_range(0, 255)));
        put(B_IAC);
        put(B_SE);
      end
    end
    put(B_LF);
    stim_total = link_bytes.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (bytes_sent < stim_total) @(posedge clk);
    while (exp_line_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb_top: %0d link bytes sent (%0d line characters from the builders)",
             bytes_sent, planned);
    $display("tb_top: %0d lines emitted, %0d discarded after overflow",
             lines_closed, lines_dropped);
    $display("tb_top: %0d line characters compared, %0d mismatches", chars_checked, err_cnt);
    if (err_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // driver: one raw byte per input transaction
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        absorb_byte(rx_byte);
        bytes_sent++;
      end
      phase = (stim_total > 0) ? (bytes_sent * 3) / stim_total : 0;
      if (!in_valid || in_ready) begin
        if (link_bytes.size() > 0 &&
            $urandom_range(0, 99) >= (phase == 0 ? 14 : (phase == 1 ? 87 : 0))) begin
          in_valid <= 1'b1;
          rx_byte  <= link_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each output transaction against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (exp_line_q.size() == 0) begin
          $error("unexpected output: line_byte %0d last_of_line %0d", line_byte, last_of_line);
          err_cnt++;
        end else begin
          exp_r = exp_line_q.pop_front();
          chars_checked++;
          if (line_byte !== exp_r.ch) begin
            $error("line_byte: expected %0d, got %0d", exp_r.ch, line_byte);
            err_cnt++;
          end
          if (last_of_line !== exp_r.last) begin
            $error("last_of_line: expected %0d, got %0d", exp_r.last, last_of_line);
            err_cnt++;
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= (phase == 0 ? 87 : (phase == 1 ? 14 : 0)));
    end
  end

  // watchdog on cycles without any transaction
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb_top: errors");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/tlr_pkg.sv
rtl/tlr_ram.sv
rtl/telnet_line_receiver_unit.sv
dv/tb_top.sv
